// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PSIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define PSIC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/psic_pkg.sv =====
// ---------------------------------------------------------------------------
// psic_pkg
// Types and constants of the pitch stability and intonation check.
// ---------------------------------------------------------------------------
`default_nettype none

package psic_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int MIN_SAMPLES_DEF  = 10;

  localparam int FREQ_W    = 17;
  localparam int EXP_W     = 18;
  localparam int CONF_W    = 8;
  localparam int LIM_W     = 16;
  localparam int HOLD_W    = 16;
  localparam int TOL_W     = 12;
  localparam int DEV_W     = 13;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int REQ_W     = 2;
  localparam int PHASE_W   = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  localparam int LOG_FRAC  = 24;
  localparam int LOG_IDX_W = 5;
  localparam int LOG_W     = LOG_IDX_W + LOG_FRAC;
  localparam int LOG_IT_W  = 5;
  localparam int MANT_W    = 32;
  localparam int PROD_W    = LOG_W + 17;

  localparam int DEV_SAT     = 3200;
  localparam int CENT_SCALE  = 19200;
  localparam int FRET_DIV    = 10;

  localparam logic [CFG_W-1:0] CONF_MIN_RST = 16'd179;
  localparam logic [CFG_W-1:0] STAB_LIM_RST = 16'd128;
  localparam logic [CFG_W-1:0] HOLD_MS_RST  = 16'd500;
  localparam logic [CFG_W-1:0] TUNE_TOL_RST = 16'd80;

  typedef enum logic [REQ_W-1:0] {
    REQ_PITCH   = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_RESTART = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONF_MIN = 2'd0,
    CFG_STAB_LIM = 2'd1,
    CFG_HOLD_MS  = 2'd2,
    CFG_TUNE_TOL = 2'd3
  } cfg_idx_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 3'd0,
    PH_OPEN = 3'd1,
    PH_WAIT = 3'd2,
    PH_FRET = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [4:0] {
    CS_IDLE, CS_SRD, CS_SSQ, CS_SACC, CS_VAR1, CS_VAR2, CS_VAR3, CS_VAR4,
    CS_MCRD, CS_MCLT, CS_MJCMP, CS_MCHK, CS_MFIN,
    CS_LOGF, CS_LOGE, CS_DMUL, CS_DRND, CS_RESP
  } ctrl_st_t;

  typedef enum logic [1:0] {
    LG_IDLE, LG_SQ, LG_NORM
  } log_st_t;

  typedef struct packed {
    logic [CONF_W-1:0] conf_min;
    logic [LIM_W-1:0]  stab_lim;
    logic [HOLD_W-1:0] hold_ms;
    logic [TOL_W-1:0]  tune_tol;
  } cfg_t;

  typedef struct packed {
    logic                    in_tune;
    logic signed [DEV_W-1:0] cents_dev;
    logic [EXP_W-1:0]        expected_freq;
    logic [FREQ_W-1:0]       fretted_freq;
    logic [FREQ_W-1:0]       open_freq;
    logic [PHASE_W-1:0]      phase;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/psic_win_mem.sv =====
// ---------------------------------------------------------------------------
// psic_win_mem
// Pitch window store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module psic_win_mem #(
  parameter int DEPTH  = psic_pkg::WINDOW_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [ADDR_W-1:0]           wr_addr,
  input  wire logic [psic_pkg::FREQ_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]           rd_addr,
  output      logic [psic_pkg::FREQ_W-1:0] rd_data
);

  logic [psic_pkg::FREQ_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/psic_log2.sv =====
// ---------------------------------------------------------------------------
// psic_log2
// Iterative log2 in Q.24: one squaring and one normalise step per bit.
// ---------------------------------------------------------------------------
`default_nettype none

module psic_log2 (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [psic_pkg::EXP_W-1:0] x,
  output      logic                       done,
  output      logic [psic_pkg::LOG_W-1:0] res
);

  psic_pkg::log_st_t st_r, st_nxt;
  logic [psic_pkg::MANT_W-1:0]   m_r, m_nxt;
  logic [psic_pkg::MANT_W:0]     sq_r, sq_nxt;
  logic [psic_pkg::LOG_W-1:0]    res_r, res_nxt;
  logic [psic_pkg::LOG_IT_W-1:0] it_r, it_nxt;
  logic                          done_r, done_nxt;
  logic [psic_pkg::LOG_IDX_W-1:0] lead;
  logic [2*psic_pkg::MANT_W-1:0] sq_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= psic_pkg::LG_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    sq_r  <= sq_nxt;
    res_r <= res_nxt;
    it_r  <= it_nxt;
  end

  always_comb begin
    lead = '0;
    for (int b = 0; b < psic_pkg::EXP_W; b++) begin
      if (x[b]) lead = psic_pkg::LOG_IDX_W'(b);
    end
  end

  assign sq_full = (2*psic_pkg::MANT_W)'(m_r) * (2*psic_pkg::MANT_W)'(m_r);

  always_comb begin
    st_nxt   = st_r;
    m_nxt    = m_r;
    sq_nxt   = sq_r;
    res_nxt  = res_r;
    it_nxt   = it_r;
    done_nxt = 1'b0;
    unique case (st_r)
      psic_pkg::LG_IDLE: begin
        if (start) begin
          m_nxt   = psic_pkg::MANT_W'(x) << (psic_pkg::LOG_IDX_W'(psic_pkg::MANT_W - 1) - lead);
          res_nxt = psic_pkg::LOG_W'(lead) << psic_pkg::LOG_FRAC;
          it_nxt  = '0;
          st_nxt  = psic_pkg::LG_SQ;
        end
      end
      psic_pkg::LG_SQ: begin
        sq_nxt = sq_full[2*psic_pkg::MANT_W-1:psic_pkg::MANT_W-1];
        st_nxt = psic_pkg::LG_NORM;
      end
      psic_pkg::LG_NORM: begin
        if (sq_r[psic_pkg::MANT_W]) begin
          res_nxt = res_r | (psic_pkg::LOG_W'(1)
                    << (psic_pkg::LOG_IT_W'(psic_pkg::LOG_FRAC - 1) - it_r));
          m_nxt   = sq_r[psic_pkg::MANT_W:1];
        end else begin
          m_nxt   = sq_r[psic_pkg::MANT_W-1:0];
        end
        if (it_r == psic_pkg::LOG_IT_W'(psic_pkg::LOG_FRAC - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = psic_pkg::LG_IDLE;
        end else begin
          it_nxt = it_r + 1'b1;
          st_nxt = psic_pkg::LG_SQ;
        end
      end
      default: st_nxt = psic_pkg::LG_IDLE;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

`include "assert_macros.svh"

  `PSIC_ASSERT(a_log_int_range, done_r |-> (res_r[psic_pkg::LOG_W-1:psic_pkg::LOG_FRAC] <= 5'd17), "log2 integer part out of range")
  `PSIC_NEVER(a_log_done_busy, done_r && (st_r != psic_pkg::LG_IDLE), "log2 done while busy")

endmodule

`default_nettype wire

// ===== rtl/psic_ctrl.sv =====
// ---------------------------------------------------------------------------
// psic_ctrl
// Request sequencer: window update, variance test, median search,
// phase machine and cent deviation.
// ---------------------------------------------------------------------------
`default_nettype none

module psic_ctrl #(
  parameter int WINDOW_DEPTH = psic_pkg::WINDOW_DEPTH_DEF,
  parameter int MIN_SAMPLES  = psic_pkg::MIN_SAMPLES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire psic_pkg::cfg_t              cfg,
  input  wire logic                        req_valid,
  output      logic                        req_ready,
  input  wire logic [psic_pkg::REQ_W-1:0]  req_kind,
  input  wire logic [psic_pkg::FREQ_W-1:0] req_freq,
  input  wire logic [psic_pkg::CONF_W-1:0] req_conf,
  output      logic                        res_valid,
  input  wire logic                        res_ready,
  output      psic_pkg::result_t           res
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = psic_pkg::FREQ_W + CNT_W;
  localparam int Q_W    = 2 * psic_pkg::FREQ_W + CNT_W;
  localparam int CMP_W  = 2 * SUM_W;
  localparam int NL_W   = CNT_W + psic_pkg::LIM_W;
  localparam int SQ_W   = 2 * psic_pkg::FREQ_W;
  localparam int RND_W  = psic_pkg::PROD_W - psic_pkg::LOG_FRAC;
  localparam int DIFF_W = psic_pkg::LOG_W + 1;
  localparam logic signed [psic_pkg::PROD_W-1:0] CENT_S = psic_pkg::PROD_W'(psic_pkg::CENT_SCALE);

  psic_pkg::ctrl_st_t st_r, st_nxt;
  psic_pkg::phase_t   phase_r, phase_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [ADDR_W-1:0]  wptr_r, wptr_nxt;
  logic [psic_pkg::FREQ_W-1:0] open_r, open_nxt, fret_r, fret_nxt;
  logic signed [psic_pkg::DEV_W-1:0] dev_r, dev_nxt;
  logic               tuned_r, tuned_nxt;
  logic [psic_pkg::HOLD_W-1:0] elapsed_r, elapsed_nxt;

  logic [SUM_W-1:0]   s_r, s_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [CMP_W-1:0]   p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic [NL_W-1:0]    nl_r, nl_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt, j_r, j_nxt, lt_r, lt_nxt, le_r, le_nxt;
  logic [psic_pkg::FREQ_W-1:0] cand_r, cand_nxt, vlo_r, vlo_nxt, vhi_r, vhi_nxt;
  logic [psic_pkg::LOG_W-1:0]  lf_r, lf_nxt;
  logic signed [DIFF_W-1:0]    diff_r, diff_nxt;
  logic signed [psic_pkg::PROD_W-1:0] prod_r, prod_nxt;

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
  logic [psic_pkg::FREQ_W-1:0] mem_rdata;

  logic                        log_start, log_done;
  logic [psic_pkg::EXP_W-1:0]  log_x;
  logic [psic_pkg::LOG_W-1:0]  log_res;

  logic [psic_pkg::EXP_W-1:0]  exp_f, med_sum, fdist;
  logic [psic_pkg::FREQ_W-1:0] med;
  logic [CNT_W-1:0]            fill_inc, rlo, rhi;
  logic [psic_pkg::PROD_W-1:0] mag, rnd_full;
  logic [RND_W-1:0]            rnd;
  logic [psic_pkg::DEV_W-1:0]  sat;
  logic signed [psic_pkg::PROD_W-1:0] diff_ext;

  psic_win_mem #(
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_win (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (req_freq),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  psic_log2 u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .res   (log_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= psic_pkg::CS_IDLE;
      phase_r   <= psic_pkg::PH_IDLE;
      fill_r    <= '0;
      wptr_r    <= '0;
      open_r    <= '0;
      fret_r    <= '0;
      dev_r     <= '0;
      tuned_r   <= 1'b0;
      elapsed_r <= '0;
    end else begin
      st_r      <= st_nxt;
      phase_r   <= phase_nxt;
      fill_r    <= fill_nxt;
      wptr_r    <= wptr_nxt;
      open_r    <= open_nxt;
      fret_r    <= fret_nxt;
      dev_r     <= dev_nxt;
      tuned_r   <= tuned_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    q_r    <= q_nxt;
    sq_r   <= sq_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    p3_r   <= p3_nxt;
    nl_r   <= nl_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    lt_r   <= lt_nxt;
    le_r   <= le_nxt;
    cand_r <= cand_nxt;
    vlo_r  <= vlo_nxt;
    vhi_r  <= vhi_nxt;
    lf_r   <= lf_nxt;
    diff_r <= diff_nxt;
    prod_r <= prod_nxt;
  end

  assign exp_f    = {open_r, 1'b0};
  assign med_sum  = psic_pkg::EXP_W'(vlo_r) + psic_pkg::EXP_W'(vhi_r);
  assign med      = med_sum[psic_pkg::EXP_W-1:1];
  assign fdist    = (psic_pkg::EXP_W'(med) >= exp_f) ? psic_pkg::EXP_W'(med) - exp_f
                                                     : exp_f - psic_pkg::EXP_W'(med);
  assign fill_inc = fill_r + 1'b1;
  assign rlo      = (fill_r - 1'b1) >> 1;
  assign rhi      = fill_r >> 1;
  assign diff_ext = psic_pkg::PROD_W'(diff_r);
  assign mag      = prod_r[psic_pkg::PROD_W-1] ? psic_pkg::PROD_W'(-prod_r)
                                               : psic_pkg::PROD_W'(prod_r);
  assign rnd_full = mag + (psic_pkg::PROD_W'(1) << (psic_pkg::LOG_FRAC - 1));
  assign rnd      = rnd_full[psic_pkg::PROD_W-1:psic_pkg::LOG_FRAC];
  assign sat      = (rnd > RND_W'(psic_pkg::DEV_SAT)) ? psic_pkg::DEV_W'(psic_pkg::DEV_SAT)
                                                      : psic_pkg::DEV_W'(rnd);

  always_comb begin
    st_nxt      = st_r;
    phase_nxt   = phase_r;
    fill_nxt    = fill_r;
    wptr_nxt    = wptr_r;
    open_nxt    = open_r;
    fret_nxt    = fret_r;
    dev_nxt     = dev_r;
    tuned_nxt   = tuned_r;
    elapsed_nxt = elapsed_r;
    s_nxt       = s_r;
    q_nxt       = q_r;
    sq_nxt      = sq_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    p3_nxt      = p3_r;
    nl_nxt      = nl_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    lt_nxt      = lt_r;
    le_nxt      = le_r;
    cand_nxt    = cand_r;
    vlo_nxt     = vlo_r;
    vhi_nxt     = vhi_r;
    lf_nxt      = lf_r;
    diff_nxt    = diff_r;
    prod_nxt    = prod_r;
    mem_we      = 1'b0;
    mem_waddr   = fill_r[ADDR_W-1:0];
    mem_raddr   = i_r[ADDR_W-1:0];
    log_start   = 1'b0;
    log_x       = psic_pkg::EXP_W'(fret_r);
    unique case (st_r)
      psic_pkg::CS_IDLE: begin
        if (req_valid) begin
          st_nxt = psic_pkg::CS_RESP;
          unique case (psic_pkg::req_t'(req_kind))
            psic_pkg::REQ_PITCH: begin
              if (req_conf >= cfg.conf_min) begin
                mem_we = 1'b1;
                if (fill_r < CNT_W'(WINDOW_DEPTH)) begin
                  mem_waddr = fill_r[ADDR_W-1:0];
                  fill_nxt  = fill_inc;
                end else begin
                  mem_waddr = wptr_r;
                  wptr_nxt  = (wptr_r == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
                end
                s_nxt = '0;
                q_nxt = '0;
                i_nxt = '0;
                if (phase_r != psic_pkg::PH_DONE && 32'(fill_nxt) >= MIN_SAMPLES) begin
                  st_nxt = psic_pkg::CS_SRD;
                end
              end
            end
            psic_pkg::REQ_TICK: begin
              if (elapsed_r != '1) elapsed_nxt = elapsed_r + 1'b1;
            end
            psic_pkg::REQ_RESTART: begin
              phase_nxt   = psic_pkg::PH_IDLE;
              fill_nxt    = '0;
              wptr_nxt    = '0;
              open_nxt    = '0;
              fret_nxt    = '0;
              dev_nxt     = '0;
              tuned_nxt   = 1'b0;
              elapsed_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      psic_pkg::CS_SRD: st_nxt = psic_pkg::CS_SSQ;
      psic_pkg::CS_SSQ: begin
        s_nxt  = s_r + SUM_W'(mem_rdata);
        sq_nxt = SQ_W'(mem_rdata) * SQ_W'(mem_rdata);
        st_nxt = psic_pkg::CS_SACC;
      end
      psic_pkg::CS_SACC: begin
        q_nxt = q_r + Q_W'(sq_r);
        i_nxt = i_r + 1'b1;
        st_nxt = (i_r + 1'b1 == fill_r) ? psic_pkg::CS_VAR1 : psic_pkg::CS_SRD;
      end
      psic_pkg::CS_VAR1: begin
        p1_nxt = CMP_W'(fill_r) * CMP_W'(q_r);
        st_nxt = psic_pkg::CS_VAR2;
      end
      psic_pkg::CS_VAR2: begin
        p2_nxt = CMP_W'(s_r) * CMP_W'(s_r);
        nl_nxt = NL_W'(fill_r) * NL_W'(cfg.stab_lim);
        st_nxt = psic_pkg::CS_VAR3;
      end
      psic_pkg::CS_VAR3: begin
        p3_nxt = CMP_W'(nl_r) * CMP_W'(nl_r);
        st_nxt = psic_pkg::CS_VAR4;
      end
      psic_pkg::CS_VAR4: begin
        st_nxt = psic_pkg::CS_RESP;
        i_nxt  = '0;
        if ((p1_r - p2_r) < p3_r) begin
          unique case (phase_r)
            psic_pkg::PH_IDLE, psic_pkg::PH_WAIT: st_nxt = psic_pkg::CS_MCRD;
            psic_pkg::PH_OPEN: begin
              if (elapsed_r >= cfg.hold_ms) begin
                phase_nxt   = psic_pkg::PH_WAIT;
                fill_nxt    = '0;
                wptr_nxt    = '0;
                elapsed_nxt = '0;
              end
            end
            psic_pkg::PH_FRET: begin
              if (elapsed_r >= cfg.hold_ms) begin
                phase_nxt = psic_pkg::PH_DONE;
                if (fret_r == '0 || open_r == '0) begin
                  dev_nxt   = '0;
                  tuned_nxt = 1'b0;
                end else begin
                  log_start = 1'b1;
                  st_nxt    = psic_pkg::CS_LOGF;
                end
              end
            end
            default: ;
          endcase
        end
      end
      psic_pkg::CS_MCRD: st_nxt = psic_pkg::CS_MCLT;
      psic_pkg::CS_MCLT: begin
        cand_nxt  = mem_rdata;
        mem_raddr = '0;
        j_nxt     = '0;
        lt_nxt    = '0;
        le_nxt    = '0;
        st_nxt    = psic_pkg::CS_MJCMP;
      end
      psic_pkg::CS_MJCMP: begin
        lt_nxt    = lt_r + CNT_W'(mem_rdata < cand_r);
        le_nxt    = le_r + CNT_W'(mem_rdata <= cand_r);
        mem_raddr = ADDR_W'(j_r + 1'b1);
        j_nxt     = j_r + 1'b1;
        if (j_r + 1'b1 == fill_r) st_nxt = psic_pkg::CS_MCHK;
      end
      psic_pkg::CS_MCHK: begin
        if (lt_r <= rlo && rlo < le_r) vlo_nxt = cand_r;
        if (lt_r <= rhi && rhi < le_r) vhi_nxt = cand_r;
        i_nxt  = i_r + 1'b1;
        st_nxt = (i_r + 1'b1 == fill_r) ? psic_pkg::CS_MFIN : psic_pkg::CS_MCRD;
      end
      psic_pkg::CS_MFIN: begin
        st_nxt = psic_pkg::CS_RESP;
        if (phase_r == psic_pkg::PH_IDLE) begin
          open_nxt    = med;
          phase_nxt   = psic_pkg::PH_OPEN;
          fill_nxt    = '0;
          wptr_nxt    = '0;
          elapsed_nxt = '0;
        end else if (exp_f != '0 &&
                     (22'(fdist) * 22'(psic_pkg::FRET_DIV)) < 22'(exp_f)) begin
          fret_nxt    = med;
          phase_nxt   = psic_pkg::PH_FRET;
          fill_nxt    = '0;
          wptr_nxt    = '0;
          elapsed_nxt = '0;
        end
      end
      psic_pkg::CS_LOGF: begin
        if (log_done) begin
          lf_nxt    = log_res;
          log_start = 1'b1;
          log_x     = exp_f;
          st_nxt    = psic_pkg::CS_LOGE;
        end
      end
      psic_pkg::CS_LOGE: begin
        if (log_done) begin
          diff_nxt = $signed({1'b0, lf_r}) - $signed({1'b0, log_res});
          st_nxt   = psic_pkg::CS_DMUL;
        end
      end
      psic_pkg::CS_DMUL: begin
        prod_nxt = diff_ext * CENT_S;
        st_nxt   = psic_pkg::CS_DRND;
      end
      psic_pkg::CS_DRND: begin
        dev_nxt   = prod_r[psic_pkg::PROD_W-1] ? -$signed(sat) : $signed(sat);
        tuned_nxt = (sat <= psic_pkg::DEV_W'(cfg.tune_tol));
        st_nxt    = psic_pkg::CS_RESP;
      end
      psic_pkg::CS_RESP: begin
        if (res_ready) st_nxt = psic_pkg::CS_IDLE;
      end
      default: st_nxt = psic_pkg::CS_IDLE;
    endcase
  end

  assign req_ready = (st_r == psic_pkg::CS_IDLE);
  assign res_valid = (st_r == psic_pkg::CS_RESP);

  always_comb begin
    res.phase         = phase_r;
    res.open_freq     = open_r;
    res.fretted_freq  = fret_r;
    res.expected_freq = exp_f;
    res.cents_dev     = dev_r;
    res.in_tune       = tuned_r;
  end

`include "assert_macros.svh"

  `PSIC_ASSERT(a_fill_bound, fill_r <= CNT_W'(WINDOW_DEPTH), "window fill beyond depth")
  `PSIC_ASSERT(a_tuned_done, tuned_r |-> (phase_r == psic_pkg::PH_DONE), "in-tune flag outside complete phase")
  `PSIC_ASSERT(a_dev_sat, (dev_r <= 13'sd3200) && (dev_r >= -13'sd3200), "deviation beyond saturation")

endmodule

`default_nettype wire

// ===== rtl/pitch_stability_intonation_check.sv =====
// ---------------------------------------------------------------------------
// pitch_stability_intonation_check
// Pitch window stability test and open/fretted intonation measurement.
// ---------------------------------------------------------------------------
// Requests arrive on the in_ channel: in_tuser carries the kind (pitch
// estimate, millisecond tick, restart), in_tdata the pitch and confidence.
// Every request yields exactly one result on the out_ channel holding the
// phase, stored pitches and the cent deviation after the update.
// Ticks, restarts and rejected estimates pass from idle straight to the
// result state and the output register. A variance test reads all n window
// entries one at a time through the window store's single read port; a
// median search compares each entry with every entry, and the deviation
// on entering complete takes two 24-step log2 runs on a shared squaring
// unit. One request is in flight at a time; a finished result waits in
// the output register while the next request is accepted.
// Reset (rst_n low, synchronous) clears phase, window fill and results and
// loads the register defaults. If out_tready stays low the result holds and
// the following request stalls once its own result is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module pitch_stability_intonation_check #(
  parameter int WINDOW_DEPTH = psic_pkg::WINDOW_DEPTH_DEF,
  parameter int MIN_SAMPLES  = psic_pkg::MIN_SAMPLES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [psic_pkg::IN_DATA_W-1:0]    in_tdata,  // pitch_freq, pitch_confidence
  input  wire logic [psic_pkg::REQ_W-1:0]        in_tuser,  // req_type
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [psic_pkg::OUT_DATA_W-1:0]   out_tdata, // phase, open_freq, fretted_freq,
                                                            // expected_freq, cents_dev, in_tune
  input  wire logic                              cfg_we,
  input  wire logic [psic_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire logic [psic_pkg::CFG_W-1:0]        cfg_wdata
);

  psic_pkg::cfg_t    cfg_r;
  psic_pkg::result_t res;
  logic              res_valid, res_ready;
  logic              out_valid_r;
  psic_pkg::result_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conf_min <= psic_pkg::CONF_W'(psic_pkg::CONF_MIN_RST);
      cfg_r.stab_lim <= psic_pkg::LIM_W'(psic_pkg::STAB_LIM_RST);
      cfg_r.hold_ms  <= psic_pkg::HOLD_W'(psic_pkg::HOLD_MS_RST);
      cfg_r.tune_tol <= psic_pkg::TOL_W'(psic_pkg::TUNE_TOL_RST);
    end else if (cfg_we) begin
      unique case (psic_pkg::cfg_idx_t'(cfg_addr))
        psic_pkg::CFG_CONF_MIN: cfg_r.conf_min <= cfg_wdata[psic_pkg::CONF_W-1:0];
        psic_pkg::CFG_STAB_LIM: cfg_r.stab_lim <= cfg_wdata[psic_pkg::LIM_W-1:0];
        psic_pkg::CFG_HOLD_MS:  cfg_r.hold_ms  <= cfg_wdata[psic_pkg::HOLD_W-1:0];
        psic_pkg::CFG_TUNE_TOL: cfg_r.tune_tol <= cfg_wdata[psic_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  psic_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MIN_SAMPLES  (MIN_SAMPLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (in_tuser),
    .req_freq  (in_tdata[psic_pkg::FREQ_W-1:0]),
    .req_conf  (in_tdata[psic_pkg::FREQ_W+psic_pkg::CONF_W-1:psic_pkg::FREQ_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = psic_pkg::OUT_DATA_W'(out_data_r);

endmodule

`default_nettype wire
